@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition a implies condition c in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// condition a implies condition c in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

@@ rtl/smsd_pkg.sv @@
// ---------------------------------------------------------------------------
// smsd_pkg
// Shared types and constants of the sliding median spike detector
// ---------------------------------------------------------------------------
package smsd_pkg;

	localparam int WINDOW_MAX  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int CFG_BITS    = 6;
	localparam int IDX_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W       = $clog2(WINDOW_MAX + 1);

	localparam logic [CFG_BITS-1:0]   WL_RESET  = CFG_BITS'(5);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last_sample;
	} in_beat_t;

	typedef struct packed {
		logic                  alert;
		logic                  window_full;
		logic [COUNT_BITS-1:0] alert_count;
		logic                  sequence_end;
	} out_beat_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic shift;   // take the neighbor's history sample
		logic load;    // copy own sample into the probe, clear counts
		logic scan;    // compare against probe, pass probe along
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_PICK,
		ST_DONE
	} state_t;

endpackage

@@ rtl/smsd_cell.sv @@
// ---------------------------------------------------------------------------
// smsd_cell
// One window cell: a history sample, a passing probe and its rank counters
// ---------------------------------------------------------------------------
module smsd_cell
	import smsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       active,
	input  cnt_t       mid,
	input  sample_t    hist_in,
	input  sample_t    probe_in,
	output sample_t    hist,
	output sample_t    probe,
	output logic       hit,
	output sample_t    pick
);

	sample_t hist_q;
	sample_t probe_q;
	cnt_t    lt_q;
	cnt_t    le_q;

	// history chain, newest sample enters at cell zero
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q <= hist_in;
		end
	end

	// probe ring, one neighbor per cycle
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			probe_q <= hist_q;
		end else if (ctrl.scan) begin
			probe_q <= probe_in;
		end
	end

	// rank counters: probes below and probes not above this sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctrl.load) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctrl.scan) begin
			lt_q <= lt_q + cnt_t'(probe_q < hist_q);
			le_q <= le_q + cnt_t'(probe_q <= hist_q);
		end
	end

	// this sample sits at the middle rank when lt <= mid < le
	assign hit   = active && (lt_q <= mid) && (le_q > mid);
	assign pick  = hit ? hist_q : '0;
	assign hist  = hist_q;
	assign probe = probe_q;

endmodule

@@ rtl/sliding_median_spike_detector.sv @@
// ---------------------------------------------------------------------------
// sliding_median_spike_detector
// Flags samples at least twice the median of the preceding window
// ---------------------------------------------------------------------------
// Samples arrive on the sample channel (valid/ready), one 16-bit value per
// beat plus a last flag. Each sample gives one result beat on the result
// channel: alert, window_full, running alert count and the echoed last flag.
// The window length (1..32, 0 acts as 1, larger acts as 32) is written
// through cfg_wen/cfg_wdata; the user must write it only while the block
// is idle, the block itself does not enforce this. The window lives in a
// row of 32 cells, newest sample in cell zero. For a full window every
// cell copies its sample into a probe, the probes travel once around the
// first L cells (L = window length) while each cell counts how many are
// below and not above its own sample, and the cell at the middle rank
// gives the median. A full-window sample passes the load, scan, pick and
// done states before its result goes to the result register, others go
// straight to done; the next sample is taken only after that commit.
// A new sample is accepted while a finished result still waits in the
// output register; if the receiver stalls, the next item stops before its
// commit until that register frees. Reset clears the count, the fill level
// and the handshake state; the window length returns to 5. A last sample
// clears the count and fill level after its result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_spike_detector
	import smsd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  in_beat_t            sample_beat,
	output logic                result_valid,
	input  logic                result_ready,
	output out_beat_t           result_beat,
	input  logic                cfg_wen,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	state_t                state_q;
	state_t                state_d;
	logic [CFG_BITS-1:0]   wl_q;
	cnt_t                  len;
	cnt_t                  len_q;
	idx_t                  step_q;
	cnt_t                  fill_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] total_d;
	sample_t               sample_q;
	logic                  last_q;
	logic                  full_q;
	sample_t               med_q;
	logic                  out_valid_q;
	out_beat_t             res_q;
	logic                  accept;
	logic                  commit;
	logic                  alert;
	cell_ctrl_t            ctrl;
	cnt_t                  mid;
	idx_t                  len_m1;

	sample_t               hist_v  [WINDOW_MAX];
	sample_t               probe_v [WINDOW_MAX];
	sample_t               pick_v  [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] hit_v;
	sample_t               pick_or;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WL_RESET;
		end else if (cfg_wen) begin
			wl_q <= cfg_wdata;
		end
	end

	// effective window length
	always_comb begin
		if (wl_q == '0) begin
			len = cnt_t'(1);
		end else if (int'(wl_q) > WINDOW_MAX) begin
			len = cnt_t'(WINDOW_MAX);
		end else begin
			len = cnt_t'(wl_q);
		end
	end

	assign accept = sample_valid && sample_ready;
	assign mid    = len_q >> 1;
	assign len_m1 = idx_t'(len_q - cnt_t'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (fill_q >= len) ? ST_LOAD : ST_DONE;
				end
			end
			ST_LOAD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (step_q == len_m1) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		commit       = 1'b0;
		ctrl         = '0;
		case (state_q)
			ST_IDLE: sample_ready = 1'b1;
			ST_LOAD: ctrl.load = 1'b1;
			ST_SCAN: ctrl.scan = 1'b1;
			ST_PICK: ;
			ST_DONE: begin
				commit     = !out_valid_q || result_ready;
				ctrl.shift = commit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_beat.sample;
			last_q   <= sample_beat.last_sample;
			full_q   <= fill_q >= len;
			len_q    <= len;
		end
	end

	// probe step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctrl.load) begin
			step_q <= '0;
		end else if (ctrl.scan) begin
			step_q <= step_q + idx_t'(1);
		end
	end

	// cell row
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		sample_t hist_in;
		sample_t probe_in;
		logic    active;

		if (i == 0) begin : g_head
			assign hist_in  = sample_q;
			assign probe_in = probe_v[len_m1];
		end else begin : g_body
			assign hist_in  = hist_v[i-1];
			assign probe_in = probe_v[i-1];
		end
		assign active = i < int'(len_q);

		smsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.active   (active),
			.mid      (mid),
			.hist_in  (hist_in),
			.probe_in (probe_in),
			.hist     (hist_v[i]),
			.probe    (probe_v[i]),
			.hit      (hit_v[i]),
			.pick     (pick_v[i])
		);
	end

	// gather the median; every hitting cell holds the same value
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			pick_or = pick_or | pick_v[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			med_q <= pick_or;
		end
	end

	// alert decision and saturating count
	assign alert = full_q && ({1'b0, sample_q} >= {med_q, 1'b0});

	always_comb begin
		total_d = total_q;
		if (alert && total_q != COUNT_MAX) begin
			total_d = total_q + COUNT_BITS'(1);
		end
	end

	// sequence state, cleared after a last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
		end else if (commit) begin
			if (last_q) begin
				fill_q  <= '0;
				total_q <= '0;
			end else begin
				total_q <= total_d;
				if (fill_q != cnt_t'(WINDOW_MAX)) begin
					fill_q <= fill_q + cnt_t'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q.alert        <= alert;
			res_q.window_full  <= full_q;
			res_q.alert_count  <= total_d;
			res_q.sequence_end <= last_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_beat  = res_q;

	// checks
	`ASSERT_IMPLIES(a_step_range, clk, arst_n, state_q == ST_SCAN, step_q <= len_m1)
	`ASSERT_IMPLIES(a_median_found, clk, arst_n, state_q == ST_PICK, hit_v != '0)
	`ASSERT_IMPLIES(a_full_window, clk, arst_n, commit && full_q, fill_q >= len_q)
	`ASSERT_NEXT(a_count_grows, clk, arst_n, commit && !last_q, total_q >= $past(total_q))

endmodule

@@ bench/sliding_median_spike_detector_tb.sv @@
// ---------------------------------------------------------------------------
// sliding_median_spike_detector_tb
// Self-checking bench for the sliding median spike detector
// ---------------------------------------------------------------------------
// A table of directed rows opens the run: field extremes, window lengths of
// zero and above the maximum, an even window, a length change in the middle
// of a sequence and the end of a sequence. Random phases follow, each with
// its own window setting and idle and stall rates. Their sequences mix a
// steady base level with spikes near twice the base and full-range noise,
// and some end early. A run of zeros at window length one alerts on every
// beat after the first, with no idling. Each result beat is checked field
// by field against a behavioral in-bench median predictor or a typed row.
// ---------------------------------------------------------------------------
module sliding_median_spike_detector_tb;
	import smsd_pkg::*;

	localparam int unsigned RAND_ITEMS = 1650;
	localparam int unsigned CALM_ITEMS = 200;
	localparam int unsigned ZERO_RUN   = 64;
	localparam int unsigned STUCK_MAX  = 2000;
	localparam int unsigned TAIL_WAIT  = 50;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_SET_WINDOW
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [SAMPLE_BITS-1:0] value;
		logic last;
		logic typed;
		out_beat_t res;
	} dir_row_t;

	localparam out_beat_t QUIET     = '{1'b0, 1'b0, 16'd0, 1'b0};
	localparam out_beat_t QUIET_END = '{1'b0, 1'b0, 16'd0, 1'b1};

	localparam int unsigned DIR_N = 26;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// reset window of five, extremes while filling
		'{ROW_SAMPLE, 16'h0000, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h0001, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h8000, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h1234, 1'b0, 1'b1, QUIET},
		// zero length acts as one, sample exactly at twice the median
		'{ROW_SET_WINDOW, 16'h0000, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h2468, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h2467, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, QUIET},
		// length above the maximum acts as the maximum
		'{ROW_SET_WINDOW, 16'h003F, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, QUIET_END},
		// even window takes the upper median
		'{ROW_SET_WINDOW, 16'h0002, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h0010, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h0030, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h0060, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, QUIET},
		// length change inside a sequence uses the stored samples
		'{ROW_SET_WINDOW, 16'h0004, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h00C0, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, QUIET},
		'{ROW_SET_WINDOW, 16'h0020, 1'b0, 1'b0, QUIET},
		'{ROW_SAMPLE, 16'h8000, 1'b0, 1'b1, QUIET},
		'{ROW_SAMPLE, 16'h7FFF, 1'b1, 1'b1, QUIET_END}
	};

	localparam int unsigned PICK_N = 13;
	localparam logic [CFG_BITS-1:0] WIN_PICKS [PICK_N] = '{
		6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd7, 6'd8, 6'd15, 6'd16, 6'd31, 6'd32, 6'd33, 6'd63
	};
	localparam int unsigned PCT_PICKS [4] = '{0, 5, 20, 50};

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	in_beat_t sample_beat;
	logic result_valid;
	logic result_ready;
	out_beat_t result_beat;
	logic cfg_wen;
	logic [CFG_BITS-1:0] cfg_wdata;

	// predictor state
	sample_t hist_mem [WINDOW_MAX];
	int unsigned fill_n;
	int unsigned head_ptr;
	logic [COUNT_BITS-1:0] alert_run;
	logic [CFG_BITS-1:0] win_reg;

	out_beat_t expected_q [$];

	int unsigned errors_n;
	int unsigned items_n;
	int unsigned rand_n;
	int unsigned results_n;
	int unsigned full_n;
	int unsigned alerts_n;
	int unsigned ends_n;
	int unsigned cfg_n;
	int unsigned stuck_n;
	logic [COUNT_BITS-1:0] peak_count;
	int unsigned idle_pct;
	int unsigned stall_pct;
	bit calm;

	sliding_median_spike_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_beat (sample_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_beat (result_beat),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// zero acts as one, anything past the maximum acts as the maximum
	function automatic int unsigned eff_window(logic [CFG_BITS-1:0] cfg);
		if (cfg == 0)
			return 1;
		if (cfg > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(cfg);
	endfunction

	// expected result of one sample, advances the predictor state
	function automatic out_beat_t median_spike_predict(in_beat_t b);
		sample_t ranked [WINDOW_MAX];
		sample_t v;
		sample_t med;
		int unsigned len;
		int unsigned p;
		int unsigned slot;
		out_beat_t res;
		len = eff_window(win_reg);
		res = '0;
		res.window_full = (fill_n >= len);
		if (res.window_full) begin
			// insertion sort of the newest len samples
			for (int k = 0; k < len; k++) begin
				slot = (head_ptr + WINDOW_MAX - 1 - k) % WINDOW_MAX;
				v = hist_mem[slot];
				p = k;
				while (p > 0 && ranked[p - 1] > v) begin
					ranked[p] = ranked[p - 1];
					p--;
				end
				ranked[p] = v;
			end
			med = ranked[len / 2];
			res.alert = ({1'b0, b.sample} >= {med, 1'b0});
		end
		if (res.alert && alert_run != COUNT_MAX)
			alert_run++;
		hist_mem[head_ptr] = b.sample;
		head_ptr = (head_ptr + 1) % WINDOW_MAX;
		if (fill_n < WINDOW_MAX)
			fill_n++;
		res.alert_count = alert_run;
		res.sequence_end = b.last_sample;
		if (b.last_sample) begin
			fill_n = 0;
			head_ptr = 0;
			alert_run = '0;
		end
		return res;
	endfunction

	// base level, spikes around twice the base, and full-range noise
	function automatic sample_t pick_sample(int unsigned base, int unsigned jitter);
		int unsigned roll;
		int unsigned v;
		roll = $urandom_range(99);
		if (roll < 8)
			v = $urandom_range(16'hFFFF);
		else if (roll < 18)
			v = 2 * base + $urandom_range(1);
		else if (roll < 24)
			v = (base == 0) ? 0 : 2 * base - 1;
		else
			v = base + $urandom_range(jitter);
		return sample_t'(v);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors_n++;
	endtask

	// one sample beat, then an optional idle burst
	task automatic push_sample(input sample_t value, input logic is_last, input logic typed,
		input out_beat_t typed_res);
		in_beat_t b;
		out_beat_t res;
		b.sample = value;
		b.last_sample = is_last;
		sample_valid <= 1'b1;
		sample_beat <= b;
		do @(posedge clk); while (!sample_ready);
		res = median_spike_predict(b);
		expected_q.push_back(typed ? typed_res : res);
		items_n++;
		@(negedge clk);
		if (!calm && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(negedge clk);
		end
	endtask

	// hold off the sender until every pending result is back
	task automatic settle();
		sample_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input logic [CFG_BITS-1:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		win_reg = value;
		cfg_n++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// a few sequences at the current window, some cut short
	task automatic run_phase(input int unsigned span);
		int unsigned budget;
		int unsigned seq_len;
		int unsigned base;
		int unsigned jitter;
		logic is_last;
		bit open_end;
		budget = $urandom_range(160, 60);
		while (budget > 0) begin
			if ($urandom_range(3) == 0)
				seq_len = $urandom_range(span, 1);
			else
				seq_len = $urandom_range(2 * span + 12, span + 1);
			open_end = (seq_len >= budget) && ($urandom_range(9) < 3);
			base = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(16'h7FFF);
			jitter = $urandom_range(1) ? 3 : base / 8;
			for (int j = 0; j < seq_len; j++) begin
				if (j == seq_len - 1)
					is_last = !open_end;
				else
					is_last = ($urandom_range(99) < 3);
				push_sample(pick_sample(base, jitter), is_last, 1'b0, QUIET);
				rand_n++;
			end
			budget = (seq_len >= budget) ? 0 : budget - seq_len;
		end
	endtask

	// random burst stalls on the result side
	initial begin
		int unsigned gap;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				result_ready <= 1'b0;
				gap = $urandom_range(15, 1);
				repeat (gap - 1) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// result beat check against the oldest expectation
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing pending", results_n));
			end else begin
				want = expected_q.pop_front();
				if (result_beat.alert !== want.alert)
					report_mismatch($sformatf("beat %0d alert got %b want %b",
						results_n, result_beat.alert, want.alert));
				if (result_beat.window_full !== want.window_full)
					report_mismatch($sformatf("beat %0d window_full got %b want %b",
						results_n, result_beat.window_full, want.window_full));
				if (result_beat.alert_count !== want.alert_count)
					report_mismatch($sformatf("beat %0d alert_count got %0d want %0d",
						results_n, result_beat.alert_count, want.alert_count));
				if (result_beat.sequence_end !== want.sequence_end)
					report_mismatch($sformatf("beat %0d sequence_end got %b want %b",
						results_n, result_beat.sequence_end, want.sequence_end));
			end
			results_n++;
			if (result_beat.window_full === 1'b1)
				full_n++;
			if (result_beat.alert === 1'b1)
				alerts_n++;
			if (result_beat.sequence_end === 1'b1)
				ends_n++;
			if (result_beat.alert_count > peak_count)
				peak_count = result_beat.alert_count;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
			stuck_n <= 0;
		else
			stuck_n <= stuck_n + 1;
		if (stuck_n >= STUCK_MAX) begin
			$display("timeout at %0t with %0d results pending", $time, expected_q.size());
			$display("sliding_median_spike_detector_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		logic [CFG_BITS-1:0] wl;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_beat = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		idle_pct = 10;
		stall_pct = 10;
		errors_n = 0;
		items_n = 0;
		rand_n = 0;
		results_n = 0;
		full_n = 0;
		alerts_n = 0;
		ends_n = 0;
		cfg_n = 0;
		peak_count = '0;
		win_reg = WL_RESET;
		fill_n = 0;
		head_ptr = 0;
		alert_run = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_SET_WINDOW) begin
				settle();
				set_window(DIR_ROWS[i].value[CFG_BITS-1:0]);
			end else begin
				push_sample(DIR_ROWS[i].value, DIR_ROWS[i].last, DIR_ROWS[i].typed,
					DIR_ROWS[i].res);
			end
		end

		// random phases with idling on both sides
		phase = 0;
		while (rand_n < RAND_ITEMS - CALM_ITEMS) begin
			settle();
			wl = (phase < PICK_N) ? WIN_PICKS[phase] : CFG_BITS'($urandom_range(63));
			set_window(wl);
			idle_pct = PCT_PICKS[$urandom_range(3)];
			stall_pct = PCT_PICKS[$urandom_range(3)];
			run_phase(eff_window(wl));
			phase++;
		end

		// no idling from here on: zeros that alert after the first beat, then random
		calm = 1'b1;
		settle();
		set_window(CFG_BITS'(1));
		for (int unsigned n = 0; n < ZERO_RUN; n++)
			push_sample('0, n == ZERO_RUN - 1, 1'b0, QUIET);
		while (rand_n < RAND_ITEMS) begin
			settle();
			wl = CFG_BITS'($urandom_range(63));
			set_window(wl);
			run_phase(eff_window(wl));
		end

		settle();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("covered %0d samples (%0d random), %0d window writes, %0d phases",
			items_n, rand_n, cfg_n, phase);
		$display("saw %0d full windows, %0d alerts, %0d sequence ends, peak count %0d",
			full_n, alerts_n, ends_n, peak_count);
		if (errors_n == 0 && expected_q.size() == 0)
			$display("sliding_median_spike_detector_tb OK");
		else
			$display("sliding_median_spike_detector_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/smsd_pkg.sv
rtl/smsd_cell.sv
rtl/sliding_median_spike_detector.sv
bench/sliding_median_spike_detector_tb.sv
